@@ hdl/timer_min_heap_macros.svh @@
// assertion macros for the timer min-heap
`ifndef TIMER_MIN_HEAP_MACROS_SVH
`define TIMER_MIN_HEAP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TMH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TMH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tmh_pkg.sv @@
// shared types and constants for the timer min-heap
package tmh_pkg;

    localparam int KEY_BITS     = 32;
    localparam int HANDLE_BITS  = 10;
    localparam int COUNT_BITS   = 11;
    localparam int CAPACITY_DEF = 1024;

    // operation codes
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]             operation;
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] entry_id;
    } tmh_in_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [KEY_BITS-1:0]    out_key;
        logic [HANDLE_BITS-1:0] out_entry_id;
        logic [COUNT_BITS-1:0]  count;
    } tmh_out_t;

    // one heap slot as held in the entry memory
    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
    } tmh_entry_t;

endpackage

@@ hdl/tmh_ram.sv @@
// generic simple dual-port ram with registered read
module tmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/tmh_ctrl.sv @@
// heap sequencer: sift-up and sift-down over the entry memory
module tmh_ctrl import tmh_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int AW      = $clog2(CAPACITY),
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  tmh_in_t       req,
    output logic          busy,
    output logic          res_valid,
    input  logic          res_ready,
    output tmh_out_t      res,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output tmh_entry_t    mem_wdata,
    output logic [AW-1:0] mem_raddr,
    input  tmh_entry_t    mem_rdata
);

    localparam int IW = AW + 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_UP   = 8'b0000_0010,
        S_ROOT = 8'b0000_0100,
        S_LAST = 8'b0000_1000,
        S_LEFT = 8'b0001_0000,
        S_CMP  = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [AW-1:0]          pos_reg, pos_next;
    tmh_entry_t             item_reg, item_next;
    tmh_entry_t             left_reg, left_next;
    logic                   pop_reg, pop_next;
    logic [1:0]             status_reg, status_next;
    logic [KEY_BITS-1:0]    rkey_reg, rkey_next;
    logic [HANDLE_BITS-1:0] rid_reg, rid_next;

    logic [IW-1:0]          n_ext;
    logic [IW-1:0]          left_idx, right_idx, chosen_idx, new_left;
    logic                   pick_right;
    tmh_entry_t             chosen;
    logic [AW-1:0]          start_pos, start_par, par, par_par;
    logic [CW-1:0]          cnt_m1;

    // index arithmetic
    always_comb
    begin
        n_ext      = IW'(count_reg);
        left_idx   = {pos_reg, 1'b1};
        right_idx  = left_idx + IW'(1);
        // right child wins a tie
        pick_right = (right_idx < n_ext) && !(mem_rdata.key > left_reg.key);
        chosen     = pick_right ? mem_rdata : left_reg;
        chosen_idx = pick_right ? right_idx : left_idx;
        new_left   = {chosen_idx[AW-1:0], 1'b1};
        start_pos  = count_reg[AW-1:0];
        start_par  = (start_pos - AW'(1)) >> 1;
        par        = (pos_reg - AW'(1)) >> 1;
        par_par    = (par - AW'(1)) >> 1;
        cnt_m1     = count_reg - CW'(1);
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        item_next   = item_reg;
        left_next   = left_reg;
        pop_next    = pop_reg;
        status_next = status_reg;
        rkey_next   = rkey_reg;
        rid_next    = rid_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = item_reg;
        mem_raddr   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    status_next = ST_OK;
                    rkey_next   = '0;
                    rid_next    = '0;
                    pop_next    = (req.operation == OP_POP);
                    item_next   = '{key: req.key, handle: req.entry_id};
                    state_next  = S_DONE;
                    case (req.operation)
                        OP_PUSH:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                                pos_next   = start_pos;
                                if (count_reg == '0)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = '0;
                                    mem_wdata = '{key: req.key, handle: req.entry_id};
                                end
                                else
                                begin
                                    mem_raddr  = start_par;
                                    state_next = S_UP;
                                end
                            end
                        end
                        OP_POP, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_raddr  = '0;
                                state_next = S_ROOT;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                // parent arrives; move it down while it is strictly greater
                if (mem_rdata.key > item_reg.key)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    pos_next  = par;
                    if (par == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        mem_raddr = par_par;
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_ROOT:
            begin
                rkey_next = mem_rdata.key;
                rid_next  = mem_rdata.handle;
                if (!pop_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    count_next = cnt_m1;
                    if (count_reg == CW'(1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mem_raddr  = cnt_m1[AW-1:0];
                        state_next = S_LAST;
                    end
                end
            end
            S_LAST:
            begin
                // last entry arrives and restarts at the root
                item_next = mem_rdata;
                pos_next  = '0;
                if (count_reg == CW'(1))
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = mem_rdata;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr  = AW'(1);
                    state_next = S_LEFT;
                end
            end
            S_LEFT:
            begin
                left_next  = mem_rdata;
                mem_raddr  = right_idx[AW-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (item_reg.key > chosen.key)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = chosen;
                    pos_next  = chosen_idx[AW-1:0];
                    if (new_left >= n_ext)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        mem_raddr  = new_left[AW-1:0];
                        state_next = S_LEFT;
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_FIN:
            begin
                mem_we     = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        item_reg   <= item_next;
        left_reg   <= left_next;
        pop_reg    <= pop_next;
        status_reg <= status_next;
        rkey_reg   <= rkey_next;
        rid_reg    <= rid_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = '{status:       status_reg,
                         out_key:      rkey_reg,
                         out_entry_id: rid_reg,
                         count:        COUNT_BITS'(count_reg)};

endmodule

@@ hdl/timer_min_heap.sv @@
// top level of the timer min-heap: entry memory, sequencer and result register
// Binary min-heap of timer entries (expiry key plus 10-bit handle), one request
// beat at a time: push, pop minimum or peek minimum, each answered by exactly
// one result beat carrying status, key, handle and the entry count afterwards.
// The whole heap lives in a single entry ram with one write and one registered
// read port; that read port sets the pace. A push does one ram read and one
// write per level that the new entry climbs. A pop reads the root and the last
// entry, then reads the left and then the right child per level that the moved
// entry sinks. After a result leaves the sequencer, the sequencer returns to
// idle before the next request beat is taken. The ram needs no clearing after
// reset: only entries in slots below the count are ever used. The count port is
// COUNT_BITS wide, so CAPACITY must stay below 2**COUNT_BITS.
`include "timer_min_heap_macros.svh"

module timer_min_heap import tmh_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  tmh_in_t  req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output tmh_out_t rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int EW = $bits(tmh_entry_t);

    // sequencer to result register
    logic          busy;
    logic          res_valid;
    logic          res_ready;
    tmh_out_t      res;

    // sequencer to entry ram
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    tmh_entry_t    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata_raw;
    tmh_entry_t    mem_rdata;

    // result register
    logic          rsp_valid_reg, rsp_valid_next;
    tmh_out_t      rsp_reg, rsp_next;

    assign mem_rdata = tmh_entry_t'(mem_rdata_raw);

    tmh_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (EW'(mem_wdata)),
        .raddr (mem_raddr),
        .rdata (mem_rdata_raw)
    );

    tmh_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .busy      (busy),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // request side: one item in flight in the sequencer
    assign req_stall = busy;

    // result register frees the sequencer as soon as the slot is empty or draining
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (!rsp_stall)
        begin
            // beat taken, nothing new to load
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks on the heap logic
    `TMH_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "idle after accept")
    `TMH_ASSERT_NOW(a_count_bound, rsp_valid, rsp.count <= COUNT_BITS'(CAPACITY), "count too big")
    `TMH_ASSERT_NOW(a_empty_count, rsp_valid && rsp.status == ST_EMPTY, rsp.count == '0, "empty bad")
    `TMH_ASSERT_NOW(a_full_count, rsp_valid && rsp.status == ST_FULL, rsp.count == COUNT_BITS'(CAPACITY), "full bad")

endmodule
